// ----- src/tmf_pkg.sv -----
package tmf_pkg;

	localparam int FORMAT_COUNT = 68;
	localparam int ROM_LEN = 68;
	localparam int DEEP_LEVEL = 16;
	localparam int LVL_W = $clog2(DEEP_LEVEL + 1);

	typedef struct packed {
		logic [4:0] bpb;
		logic       edge4;
	} fmt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_D,
		ST_ACC,
		ST_TAIL_MUL,
		ST_SCALE_SL,
		ST_SCALE_SA
	} state_t;

	function automatic fmt_t fmt_lookup(input logic [7:0] code);
		fmt_t f;
		f.bpb = 5'd0;
		f.edge4 = 1'b0;
		if (({1'b0, code} < 9'(FORMAT_COUNT)) && ({1'b0, code} < 9'(ROM_LEN))) begin
			if (code >= 8'd1 && code <= 8'd4) begin
				f.bpb = 5'd1;
			end else if (code >= 8'd5 && code <= 8'd16) begin
				f.bpb = 5'd2;
			end else if (code >= 8'd17 && code <= 8'd33) begin
				f.bpb = 5'd4;
			end else if (code >= 8'd34 && code <= 8'd41) begin
				f.bpb = 5'd8;
			end else if (code >= 8'd42 && code <= 8'd44) begin
				f.bpb = 5'd12;
			end else if (code >= 8'd45 && code <= 8'd47) begin
				f.bpb = 5'd16;
			end else if (code == 8'd48) begin
				f.bpb = 5'd2;
			end else if (code >= 8'd49 && code <= 8'd51) begin
				f.bpb = 5'd4;
			end else if (code >= 8'd52 && code <= 8'd53) begin
				f.bpb = 5'd8;
			end else if (code >= 8'd54 && code <= 8'd55) begin
				f.bpb = 5'd8;
				f.edge4 = 1'b1;
			end else if (code >= 8'd56 && code <= 8'd59) begin
				f.bpb = 5'd16;
				f.edge4 = 1'b1;
			end else if (code >= 8'd60 && code <= 8'd61) begin
				f.bpb = 5'd8;
				f.edge4 = 1'b1;
			end else if (code >= 8'd62 && code <= 8'd67) begin
				f.bpb = 5'd16;
				f.edge4 = 1'b1;
			end
		end
		return f;
	endfunction

endpackage

// ----- src/texture_memory_footprint.sv -----
// channel  | handshake          | fields
// request  | start in, busy out | format_code, width, height, depth,
//          |                    | array_slices, sample_count, mip_count
// result   | done out (strobe)  | total_bytes
//
// one shared 64x16 multiplier does all products; each mip level below 16 runs
// MUL_X, MUL_Y, MUL_D, ACC; levels 16 and up each add one block's bytes,
// all in one tail multiply, then the sum is scaled by slices and by samples
// busy is high from the accepted request until done; asynchronous reset idles
// done lasts one cycle and cannot be stalled; total_bytes holds to next accept
module texture_memory_footprint import tmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  format_code,
	input  logic [15:0] width,
	input  logic [15:0] height,
	input  logic [15:0] depth,
	input  logic [15:0] array_slices,
	input  logic [7:0]  sample_count,
	input  logic [7:0]  mip_count,
	output logic        done,
	output logic [63:0] total_bytes
);

	state_t state_q, state_d;

	fmt_t        fmt_q;
	logic [15:0] width_q, height_q, depth_q, slices_q;
	logic [7:0]  samples_q, mips_q;
	logic [LVL_W-1:0] lvl_q;
	logic [63:0] p_q, sum_q;
	logic        done_q;

	fmt_t        fmt_in;
	logic [15:0] bx, by, bd;
	logic [63:0] mul_a, mul_p;
	logic [15:0] mul_b;
	logic [LVL_W-1:0] lvl_next;
	logic [7:0]  tail_cnt;
	logic        accept;

	assign accept = start && (state_q == ST_IDLE);
	assign fmt_in = fmt_lookup(format_code);
	assign lvl_next = lvl_q + 1'b1;
	assign tail_cnt = mips_q - 8'(DEEP_LEVEL);

	tmf_dims u_dim_x (
		.base   (width_q),
		.lvl    (lvl_q[LVL_W-2:0]),
		.edge4  (fmt_q.edge4),
		.blocks (bx)
	);

	tmf_dims u_dim_y (
		.base   (height_q),
		.lvl    (lvl_q[LVL_W-2:0]),
		.edge4  (fmt_q.edge4),
		.blocks (by)
	);

	tmf_dims u_dim_d (
		.base   (depth_q),
		.lvl    (lvl_q[LVL_W-2:0]),
		.edge4  (1'b0),
		.blocks (bd)
	);

	tmf_mul u_mul (
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_p)
	);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = p_q;
		mul_b = 16'd0;
		case (state_q)
			ST_MUL_X:    mul_b = bx;
			ST_MUL_Y:    mul_b = by;
			ST_MUL_D:    mul_b = bd;
			ST_TAIL_MUL: mul_b = {8'd0, tail_cnt};
			ST_SCALE_SL: begin
				mul_a = sum_q;
				mul_b = slices_q;
			end
			ST_SCALE_SA: begin
				mul_a = sum_q;
				mul_b = {8'd0, samples_q};
			end
			default:     mul_b = 16'd0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start) state_d = ST_MUL_X;
			ST_MUL_X:    state_d = ST_MUL_Y;
			ST_MUL_Y:    state_d = ST_MUL_D;
			ST_MUL_D:    state_d = ST_ACC;
			ST_ACC: begin
				if ((lvl_q == LVL_W'(DEEP_LEVEL)) ||
						({{(9-LVL_W){1'b0}}, lvl_next} == {1'b0, mips_q})) begin
					state_d = ST_SCALE_SL;
				end else if (lvl_next == LVL_W'(DEEP_LEVEL)) begin
					state_d = ST_TAIL_MUL;
				end else begin
					state_d = ST_MUL_X;
				end
			end
			ST_TAIL_MUL: state_d = ST_ACC;
			ST_SCALE_SL: state_d = ST_SCALE_SA;
			ST_SCALE_SA: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_SCALE_SA);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_q <= fmt_in;
			width_q <= width;
			height_q <= height;
			depth_q <= depth;
			slices_q <= (array_slices == 16'd0) ? 16'd1 : array_slices;
			samples_q <= (sample_count == 8'd0) ? 8'd1 : sample_count;
			mips_q <= (mip_count == 8'd0) ? 8'd1 : mip_count;
			lvl_q <= '0;
			p_q <= {59'd0, fmt_in.bpb};
			sum_q <= 64'd0;
		end else begin
			case (state_q)
				ST_MUL_X, ST_MUL_Y, ST_MUL_D, ST_TAIL_MUL: p_q <= mul_p;
				ST_ACC: begin
					sum_q <= sum_q + p_q;
					p_q <= {59'd0, fmt_q.bpb};
					if (lvl_q != LVL_W'(DEEP_LEVEL)) lvl_q <= lvl_next;
				end
				ST_SCALE_SL, ST_SCALE_SA: sum_q <= mul_p;
				default: sum_q <= sum_q;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign total_bytes = sum_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request accepted but not busy");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("work ended without a result");

	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (lvl_q <= LVL_W'(DEEP_LEVEL))) else $error("level counter overrun");

endmodule

// ----- src/tmf_mul.sv -----
module tmf_mul import tmf_pkg::*; (
	input  logic [63:0] a,
	input  logic [15:0] b,
	output logic [63:0] prod
);

	// low 64 bits only, the product wraps modulo 2^64
	assign prod = a * {48'd0, b};

endmodule

// ----- src/tmf_dims.sv -----
module tmf_dims import tmf_pkg::*; (
	input  logic [15:0]      base,
	input  logic [LVL_W-2:0] lvl,
	input  logic             edge4,
	output logic [15:0]      blocks
);

	logic [15:0] shifted;
	logic [15:0] clamped;
	logic [16:0] rounded;

	always_comb begin
		shifted = base >> lvl;
		clamped = (shifted == 16'd0) ? 16'd1 : shifted;
		rounded = {1'b0, clamped} + 17'd3;
		blocks = edge4 ? {1'b0, rounded[16:2]} : clamped;
	end

endmodule
